/* rtl/core/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

	localparam int KEY_W = 12;
	localparam int NUM_W = 16;
	localparam int HND_W = 8;
	localparam int CNT_OUT_W = 7;

	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_PEEK = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0] tko;
		logic [KEY_W-1:0] est;
		logic [NUM_W-1:0] num;
		logic [HND_W-1:0] hnd;
	} entry_t;

endpackage

/* rtl/core/spq_cmd_if.sv */
`timescale 1ns / 1ps

interface spq_cmd_if;
	logic                          valid;
	logic                          ready;
	spq_pkg::op_t                  op;
	logic [spq_pkg::KEY_W-1:0]     takeoff_time;
	logic [spq_pkg::KEY_W-1:0]     estimated_time;
	logic [spq_pkg::NUM_W-1:0]     flight_number;
	logic [spq_pkg::HND_W-1:0]     handle;

	modport source (
		output valid, op, takeoff_time, estimated_time, flight_number, handle,
		input  ready
	);
	modport sink (
		input  valid, op, takeoff_time, estimated_time, flight_number, handle,
		output ready
	);
endinterface

/* rtl/core/spq_rsp_if.sv */
`timescale 1ns / 1ps

interface spq_rsp_if;
	logic                          valid;
	logic                          ready;
	spq_pkg::status_t              status;
	logic [spq_pkg::HND_W-1:0]     out_handle;
	logic [spq_pkg::KEY_W-1:0]     out_key;
	logic [spq_pkg::NUM_W-1:0]     out_number;
	logic [spq_pkg::CNT_OUT_W-1:0] entry_count;

	modport source (
		output valid, status, out_handle, out_key, out_number, entry_count,
		input  ready
	);
	modport sink (
		input  valid, status, out_handle, out_key, out_number, entry_count,
		output ready
	);
endinterface

/* rtl/core/spq_cfg_if.sv */
`timescale 1ns / 1ps

interface spq_cfg_if;
	logic valid;
	logic ready;
	logic key_select;

	modport source (
		output valid, key_select,
		input  ready
	);
	modport sink (
		input  valid, key_select,
		output ready
	);
endinterface

/* rtl/core/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// Stable sorted priority queue, up to DEPTH entries, ordered by (key, number).
// cmd: one beat per operation (enqueue, dequeue front, peek front, no-op).
// rsp: one beat per operation with status, front entry and entry count.
// cfg: one beat writes key_select (1 = takeoff time, 0 = estimated time).
// Entries live in one single-port-write memory used as a ring from a head
// pointer. An enqueue makes one forward pass: each entry is read, compared
// and written back one place later once the insertion point is passed.
// An enqueue pass does one memory read and one write per cycle; dequeue and
// peek read the front entry (S_FRD, S_FRONT), and no-op and rejected
// operations go straight to S_FIN. cmd.ready is high only between
// operations, so one operation is in flight at a time.
// rsp is a registered output: a stalled receiver holds the beat while the
// next cmd beat is taken and worked on; its result waits until rsp is free.
// cfg.ready is always high. Reset empties the queue and clears key_select;
// the memory is not cleared and needs no clearing pass.
module sorted_priority_queue #(
	parameter int DEPTH = 64
) (
	input logic         clk,
	input logic         arst_n,
	spq_cmd_if.sink     cmd,
	spq_rsp_if.source   rsp,
	spq_cfg_if.sink     cfg
);
	import spq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ENQ,
		S_FRD,
		S_FRONT,
		S_FIN
	} state_t;

	typedef struct packed {
		status_t          status;
		logic [HND_W-1:0] hnd;
		logic [KEY_W-1:0] key;
		logic [NUM_W-1:0] num;
	} res_t;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	state_t           state_q;
	logic [CW-1:0]    occ_q;
	logic [AW-1:0]    head_q;
	logic [AW-1:0]    ra_q;
	logic [CW-1:0]    cnt_q;
	logic             ins_q;
	logic             key_select_q;
	op_t              op_q;
	entry_t           new_q;
	entry_t           carry_q;
	res_t             res_q;
	logic             rsp_valid_q;
	res_t             rsp_q;
	logic [CNT_OUT_W-1:0] rsp_cnt_q;

	logic             valid_s1;
	logic [AW-1:0]    wa_s1;
	entry_t           rd_data_s1;

	entry_t           mem [DEPTH];

	logic             mem_re;
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	entry_t           mem_wd;
	logic [KEY_W-1:0] e_key;
	logic [KEY_W-1:0] new_key;
	logic             goes_before;
	logic [31:0]      occ_ext;

	assign cmd.ready       = (state_q == S_IDLE);
	assign cfg.ready       = 1'b1;
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.out_handle  = rsp_q.hnd;
	assign rsp.out_key     = rsp_q.key;
	assign rsp.out_number  = rsp_q.num;
	assign rsp.entry_count = rsp_cnt_q;

	assign occ_ext = 32'(occ_q);

	always_comb begin
		e_key       = key_select_q ? rd_data_s1.tko : rd_data_s1.est;
		new_key     = key_select_q ? new_q.tko : new_q.est;
		goes_before = (new_key < e_key) || ((new_key == e_key) && (new_q.num < rd_data_s1.num));
		mem_re      = 1'b0;
		mem_we      = 1'b0;
		mem_wa      = wa_s1;
		mem_wd      = new_q;
		case (state_q)
			S_ENQ: begin
				mem_re = (cnt_q != occ_q);
				if (valid_s1) begin
					if (ins_q) begin
						mem_we = 1'b1;
						mem_wd = carry_q;
					end else if (goes_before) begin
						mem_we = 1'b1;
					end
				end else if (cnt_q == occ_q) begin
					mem_we = 1'b1;
					mem_wa = ra_q;
					mem_wd = ins_q ? carry_q : new_q;
				end
			end
			S_FRD: mem_re = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_s1 <= mem[ra_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			occ_q        <= '0;
			head_q       <= '0;
			ra_q         <= '0;
			cnt_q        <= '0;
			ins_q        <= 1'b0;
			valid_s1     <= 1'b0;
			key_select_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				key_select_q <= cfg.key_select;
			end
			if (rsp.ready && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q      <= cmd.op;
						new_q     <= '{tko: cmd.takeoff_time, est: cmd.estimated_time,
							num: cmd.flight_number, hnd: cmd.handle};
						ra_q      <= head_q;
						cnt_q     <= '0;
						ins_q     <= 1'b0;
						valid_s1  <= 1'b0;
						case (cmd.op)
							OP_ENQ: begin
								if (occ_q == CW'(DEPTH)) begin
									res_q   <= '{status: ST_FULL, hnd: '0, key: '0, num: '0};
									state_q <= S_FIN;
								end else begin
									res_q   <= '{status: ST_OK, hnd: '0, key: '0, num: '0};
									state_q <= S_ENQ;
								end
							end
							OP_DEQ, OP_PEEK: begin
								if (occ_q == '0) begin
									res_q   <= '{status: ST_EMPTY, hnd: '0, key: '0, num: '0};
									state_q <= S_FIN;
								end else begin
									res_q   <= '{status: ST_OK, hnd: '0, key: '0, num: '0};
									state_q <= S_FRD;
								end
							end
							default: begin
								res_q   <= '{status: ST_OK, hnd: '0, key: '0, num: '0};
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_ENQ: begin
					if (cnt_q != occ_q) begin
						ra_q     <= ptr_inc(ra_q);
						cnt_q    <= cnt_q + 1'b1;
						valid_s1 <= 1'b1;
						wa_s1    <= ra_q;
					end else begin
						valid_s1 <= 1'b0;
					end
					if (valid_s1) begin
						if (ins_q || goes_before) begin
							carry_q <= rd_data_s1;
							ins_q   <= 1'b1;
						end
					end else if (cnt_q == occ_q) begin
						occ_q   <= occ_q + 1'b1;
						state_q <= S_FIN;
					end
				end
				S_FRD: state_q <= S_FRONT;
				S_FRONT: begin
					res_q <= '{status: ST_OK, hnd: rd_data_s1.hnd,
						key: key_select_q ? rd_data_s1.tko : rd_data_s1.est,
						num: rd_data_s1.num};
					if (op_q == OP_DEQ) begin
						head_q <= ptr_inc(head_q);
						occ_q  <= occ_q - 1'b1;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= res_q;
						rsp_cnt_q   <= occ_ext[CNT_OUT_W-1:0];
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ENQ) |-> (cnt_q <= occ_q))
		else $error("insert pass ran past the entry count");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FRONT && op_q == OP_DEQ) |=> (occ_q == $past(occ_q) - 1'b1))
		else $error("dequeue did not drop the count by one");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && rsp_valid_q && !rsp.ready) |=>
			(rsp_valid_q && $stable(rsp_q) && $stable(rsp_cnt_q)))
		else $error("result overwrote a stalled beat");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import spq_pkg::*;

	localparam int QDEPTH = 64;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 80;
	localparam int STALL_CYCLES = 200;

	typedef struct {
		status_t          status;
		logic [HND_W-1:0] hnd;
		logic [KEY_W-1:0] key;
		logic [NUM_W-1:0] num;
		logic [CNT_OUT_W-1:0] count;
	} report_t;

	logic clk;
	logic arst_n;

	spq_cmd_if cmd_bus ();
	spq_rsp_if rsp_bus ();
	spq_cfg_if cfg_bus ();

	sorted_priority_queue #(
		.DEPTH(QDEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.rsp(rsp_bus),
		.cfg(cfg_bus)
	);

	// queue contents as the block should hold them
	logic [KEY_W-1:0] tko_tab [QDEPTH];
	logic [KEY_W-1:0] est_tab [QDEPTH];
	logic [NUM_W-1:0] num_tab [QDEPTH];
	logic [HND_W-1:0] hnd_tab [QDEPTH];
	int held;
	logic by_takeoff;

	report_t awaited_reports [$];
	int fail_count;
	int send_idle_pct;
	int recv_idle_pct;
	bit stall_active;
	event stall_go;
	int quiet_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic report_t apply_queue_op(op_t op, logic [KEY_W-1:0] tko,
			logic [KEY_W-1:0] est, logic [NUM_W-1:0] num, logic [HND_W-1:0] hnd);
		report_t r;
		int pos;
		logic [KEY_W-1:0] new_key;
		logic [KEY_W-1:0] k;
		r = '{ST_OK, '0, '0, '0, '0};
		case (op)
			OP_ENQ: begin
				if (held >= QDEPTH) begin
					r.status = ST_FULL;
				end else begin
					new_key = by_takeoff ? tko : est;
					pos = held;
					for (int i = 0; i < held; i++) begin
						k = by_takeoff ? tko_tab[i] : est_tab[i];
						if (new_key < k || (new_key == k && num < num_tab[i])) begin
							pos = i;
							break;
						end
					end
					for (int i = held; i > pos; i--) begin
						tko_tab[i] = tko_tab[i-1];
						est_tab[i] = est_tab[i-1];
						num_tab[i] = num_tab[i-1];
						hnd_tab[i] = hnd_tab[i-1];
					end
					tko_tab[pos] = tko;
					est_tab[pos] = est;
					num_tab[pos] = num;
					hnd_tab[pos] = hnd;
					held++;
				end
			end
			OP_DEQ, OP_PEEK: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.hnd = hnd_tab[0];
					r.key = by_takeoff ? tko_tab[0] : est_tab[0];
					r.num = num_tab[0];
					if (op == OP_DEQ) begin
						for (int i = 0; i + 1 < held; i++) begin
							tko_tab[i] = tko_tab[i+1];
							est_tab[i] = est_tab[i+1];
							num_tab[i] = num_tab[i+1];
							hnd_tab[i] = hnd_tab[i+1];
						end
						held--;
					end
				end
			end
			default: ;
		endcase
		r.count = held[CNT_OUT_W-1:0];
		return r;
	endfunction

	// valid stays high after a beat; the next call lowers or reuses it
	task automatic send_cmd(op_t op, logic [KEY_W-1:0] tko, logic [KEY_W-1:0] est,
			logic [NUM_W-1:0] num, logic [HND_W-1:0] hnd);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_bus.valid          <= 1'b1;
		cmd_bus.op             <= op;
		cmd_bus.takeoff_time   <= tko;
		cmd_bus.estimated_time <= est;
		cmd_bus.flight_number  <= num;
		cmd_bus.handle         <= hnd;
		do @(posedge clk); while (!cmd_bus.ready);
		awaited_reports.push_back(apply_queue_op(op, tko, est, num, hnd));
	endtask

	task automatic wait_drained();
		cmd_bus.valid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_key_select(logic value);
		cfg_bus.valid      <= 1'b1;
		cfg_bus.key_select <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		by_takeoff = value;
		cfg_bus.valid <= 1'b0;
	endtask

	// half the time a narrow range so ties are common
	function automatic logic [NUM_W-1:0] pick_value(int width);
		logic [NUM_W-1:0] v;
		v = ($urandom_range(1) == 0) ? NUM_W'($urandom_range(15)) : NUM_W'($urandom);
		return v & NUM_W'((32'd1 << width) - 32'd1);
	endfunction

	task automatic send_random(bit filling);
		int roll;
		op_t op;
		roll = $urandom_range(99);
		if (filling)
			op = (roll < 88) ? OP_ENQ : (roll < 93) ? OP_PEEK : (roll < 98) ? OP_DEQ : OP_NOP;
		else
			op = (roll < 75) ? OP_DEQ : (roll < 85) ? OP_PEEK : (roll < 97) ? OP_ENQ : OP_NOP;
		send_cmd(op, KEY_W'(pick_value(KEY_W)), KEY_W'(pick_value(KEY_W)),
			pick_value(NUM_W), HND_W'($urandom));
	endtask

	always @(posedge clk) begin
		if (!arst_n || (cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always begin
		@(stall_go);
		stall_active = 1'b1;
		repeat (STALL_CYCLES) @(posedge clk);
		stall_active = 1'b0;
	end

	always @(posedge clk) begin
		report_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (awaited_reports.size() == 0) begin
				$error("result beat with nothing expected, status %0d count %0d",
					rsp_bus.status, rsp_bus.entry_count);
				fail_count++;
			end else begin
				want = awaited_reports.pop_front();
				if (rsp_bus.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_bus.status);
					fail_count++;
				end
				if (rsp_bus.out_handle !== want.hnd) begin
					$error("out_handle: expected %0d, got %0d", want.hnd, rsp_bus.out_handle);
					fail_count++;
				end
				if (rsp_bus.out_key !== want.key) begin
					$error("out_key: expected %0d, got %0d", want.key, rsp_bus.out_key);
					fail_count++;
				end
				if (rsp_bus.out_number !== want.num) begin
					$error("out_number: expected %0d, got %0d", want.num, rsp_bus.out_number);
					fail_count++;
				end
				if (rsp_bus.entry_count !== want.count) begin
					$error("entry_count: expected %0d, got %0d", want.count,
						rsp_bus.entry_count);
					fail_count++;
				end
			end
		end
		rsp_bus.ready <= !stall_active && ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic test_empty_queue();
		send_cmd(OP_DEQ, '0, '0, '0, '0);
		send_cmd(OP_PEEK, '1, '1, '1, '1);
		send_cmd(OP_NOP, 12'h5A5, 12'hA5A, 16'h5A5A, 8'hA5);
		wait_drained();
	endtask

	task automatic test_key_extremes();
		send_cmd(OP_ENQ, 12'hFFF, 12'h000, 16'hFFFF, 8'hFF);
		send_cmd(OP_ENQ, 12'h000, 12'hFFF, 16'h0000, 8'h00);
		send_cmd(OP_ENQ, 12'h000, 12'h000, 16'h0000, 8'h55);
		send_cmd(OP_ENQ, 12'h800, 12'h800, 16'h8000, 8'hAA);
		send_cmd(OP_PEEK, '0, '0, '0, '0);
		repeat (4) send_cmd(OP_DEQ, '0, '0, '0, '0);
		send_cmd(OP_NOP, '0, '0, '0, '0);
		wait_drained();
	endtask

	task automatic test_tie_order();
		send_cmd(OP_ENQ, 12'd100, 12'd7, 16'd5, 8'd1);
		send_cmd(OP_ENQ, 12'd100, 12'd7, 16'd3, 8'd2);
		send_cmd(OP_ENQ, 12'd100, 12'd7, 16'd5, 8'd3);
		send_cmd(OP_ENQ, 12'd99, 12'd7, 16'd9, 8'd4);
		repeat (4) send_cmd(OP_DEQ, '0, '0, '0, '0);
		wait_drained();
	endtask

	// stored order is kept; later inserts compare with the new key
	task automatic test_key_switch();
		write_key_select(1'b0);
		send_cmd(OP_ENQ, 12'd900, 12'd10, 16'd1, 8'd10);
		send_cmd(OP_ENQ, 12'd100, 12'd20, 16'd1, 8'd20);
		wait_drained();
		write_key_select(1'b1);
		send_cmd(OP_ENQ, 12'd500, 12'd0, 16'd1, 8'd30);
		repeat (3) send_cmd(OP_DEQ, '0, '0, '0, '0);
		wait_drained();
	endtask

	// fill to full, then drain to empty, over and over
	task automatic test_random_traffic(int count);
		bit filling;
		int past_end;
		filling = 1'b1;
		past_end = 0;
		repeat (count) begin
			if ((filling && held == QDEPTH) || (!filling && held == 0))
				past_end++;
			if (past_end > $urandom_range(1, 3)) begin
				filling = !filling;
				past_end = 0;
			end
			send_random(filling);
		end
		wait_drained();
	endtask

	task automatic test_output_stall();
		send_idle_pct = 0;
		-> stall_go;
		repeat (12) send_random(1'b1);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		held = 0;
		by_takeoff = 1'b0;
		send_idle_pct = 25;
		recv_idle_pct = 54;
		cmd_bus.valid          <= 1'b0;
		cmd_bus.op             <= OP_NOP;
		cmd_bus.takeoff_time   <= '0;
		cmd_bus.estimated_time <= '0;
		cmd_bus.flight_number  <= '0;
		cmd_bus.handle         <= '0;
		cfg_bus.valid          <= 1'b0;
		cfg_bus.key_select     <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_key_select(1'b1);
		test_empty_queue();
		test_key_extremes();
		test_tie_order();
		test_key_switch();

		test_random_traffic(170);
		write_key_select(1'b0);
		send_idle_pct = 54;
		recv_idle_pct = 25;
		test_random_traffic(170);
		test_output_stall();
		write_key_select(1'b1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(160);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
